/* sv/smbc_pkg.sv */
`timescale 1ns / 1ps

package smbc_pkg;

  // Request function codes
  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_READ = 2'd1;
  localparam logic [1:0] FN_WRITE = 2'd2;
  localparam logic [1:0] FN_ACK = 2'd3;

  // Register offsets
  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_STAT = 2'd1;
  localparam logic [1:0] REG_DATA = 2'd2;

  // Control register bit positions
  localparam int C_IE = 7;
  localparam int C_EN = 6;
  localparam int C_LSB = 5;
  localparam int C_MST = 4;
  localparam int C_POL = 3;
  localparam int C_PHA = 2;

  // Internal status bit positions
  localparam int S_DONE = 0;
  localparam int S_COL = 1;
  localparam int S_X2 = 2;

  // Pin level bit positions
  localparam int P_SCK = 0;
  localparam int P_MOSI = 1;
  localparam int P_SEL = 2;
  localparam logic [2:0] PINS_RESET = 3'b110;

  // Transfer phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_LEAD = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_REL = 3'd4;

  localparam logic [3:0] BITS_FULL = 4'd8;
  localparam logic [3:0] BITS_MAX = 4'd15;

  // Half serial period in system ticks, by rate select
  localparam logic [6:0] HALF_TICKS [4] = '{7'd2, 7'd8, 7'd32, 7'd64};

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       sck_level;
    logic       mosi_level;
    logic       select_n;
    logic       lines_driven;
    logic       busy_res;
  } result_t;

  // Prescaler reload: half period, halved at double speed, minus one
  function automatic logic [5:0] reload_value(input logic [1:0] rate, input logic x2);
    logic [6:0] h;
    h = HALF_TICKS[rate] >> x2;
    return 6'(h - 7'd1);
  endfunction

endpackage

/* sv/spi_master_byte_controller.sv */
`timescale 1ns / 1ps
// A result word is registered in the result register, or in the skid register while
// the result side stalls. Throughput: one request word per cycle while req_stall is
// low; the register file and transfer sequencer update in a single pass between the
// request edge and the result register. A two-entry output (result register plus
// skid register) takes one more request while results stall. Reset clears the state
// registers and valid flags, idles the sequencer and returns the pins to sck low, mosi high, select high.

module spi_master_byte_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] func,
  input  logic [1:0] reg_sel,
  input  logic [7:0] write_data,
  input  logic       miso_level,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data,
  output logic       irq,
  output logic       sck_level,
  output logic       mosi_level,
  output logic       select_n,
  output logic       lines_driven,
  output logic       busy_res
);

  logic [7:0] control_reg, control_reg_next;
  logic [2:0] status_bits, status_bits_next;
  logic [1:0] pending_clear, pending_clear_next;
  logic [7:0] data_reg, data_reg_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [2:0] phase, phase_next;
  logic [3:0] bits_out, bits_out_next;
  logic [3:0] bits_in, bits_in_next;
  logic [5:0] prescale_count, prescale_count_next;
  logic [2:0] pin_levels, pin_levels_next;

  smbc_pkg::result_t result_next;
  smbc_pkg::result_t out_word, skid_word;
  logic out_valid, skid_valid;

  logic       accept;
  logic       pol, pha;
  logic [2:0] idx;
  logic       drv_next;
  logic [7:0] rd;
  logic [7:0] diff;

  assign accept = req_valid && !req_stall;
  assign req_stall = skid_valid;

  // Work out the next register state and the result word
  always_comb begin
    control_reg_next = control_reg;
    status_bits_next = status_bits;
    pending_clear_next = pending_clear;
    data_reg_next = data_reg;
    shift_reg_next = shift_reg;
    phase_next = phase;
    bits_out_next = bits_out;
    bits_in_next = bits_in;
    prescale_count_next = prescale_count;
    pin_levels_next = pin_levels;
    rd = 8'd0;
    diff = control_reg ^ write_data;
    pol = control_reg[smbc_pkg::C_POL];
    pha = control_reg[smbc_pkg::C_PHA];
    // bit position for the current sample or shift
    idx = control_reg[smbc_pkg::C_LSB] ? bits_in[2:0] : ~bits_in[2:0];

    case (func)
      smbc_pkg::FN_TICK: begin
        if (phase != smbc_pkg::PH_IDLE) begin
          if (prescale_count == 6'd0) begin
            case (phase)
              smbc_pkg::PH_REL: begin
                pin_levels_next[smbc_pkg::P_SEL] = 1'b1;
                phase_next = smbc_pkg::PH_IDLE;
                pending_clear_next[smbc_pkg::S_DONE] = 1'b0;
                status_bits_next[smbc_pkg::S_DONE] = 1'b1;
              end
              smbc_pkg::PH_START, smbc_pkg::PH_TRAIL: begin
                if (pha && bits_out == smbc_pkg::BITS_FULL) begin
                  pin_levels_next[smbc_pkg::P_MOSI] = 1'b1;
                  pin_levels_next[smbc_pkg::P_SEL] = 1'b1;
                  phase_next = smbc_pkg::PH_IDLE;
                  pending_clear_next[smbc_pkg::S_DONE] = 1'b0;
                  status_bits_next[smbc_pkg::S_DONE] = 1'b1;
                end else begin
                  phase_next = smbc_pkg::PH_LEAD;
                  if (!pha) begin
                    shift_reg_next[idx] = miso_level;
                    if (bits_in != smbc_pkg::BITS_MAX) bits_in_next = bits_in + 4'd1;
                    if (bits_in_next == smbc_pkg::BITS_FULL) data_reg_next = shift_reg_next;
                  end else begin
                    pin_levels_next[smbc_pkg::P_MOSI] = shift_reg[idx];
                    if (bits_out != smbc_pkg::BITS_MAX) bits_out_next = bits_out + 4'd1;
                  end
                  pin_levels_next[smbc_pkg::P_SCK] = !pol;
                end
              end
              smbc_pkg::PH_LEAD: begin
                if (!pha && bits_out == smbc_pkg::BITS_FULL) begin
                  pin_levels_next[smbc_pkg::P_MOSI] = 1'b1;
                  phase_next = smbc_pkg::PH_REL;
                  pin_levels_next[smbc_pkg::P_SCK] = pol;
                end else begin
                  phase_next = smbc_pkg::PH_TRAIL;
                  if (!pha) begin
                    pin_levels_next[smbc_pkg::P_MOSI] = shift_reg[idx];
                    if (bits_out != smbc_pkg::BITS_MAX) bits_out_next = bits_out + 4'd1;
                  end else begin
                    shift_reg_next[idx] = miso_level;
                    if (bits_in != smbc_pkg::BITS_MAX) bits_in_next = bits_in + 4'd1;
                    if (bits_in_next == smbc_pkg::BITS_FULL) begin
                      data_reg_next = shift_reg_next;
                      pending_clear_next[smbc_pkg::S_DONE] = 1'b0;
                      status_bits_next[smbc_pkg::S_DONE] = 1'b1;
                    end
                  end
                  pin_levels_next[smbc_pkg::P_SCK] = pol;
                end
              end
              default: begin
                phase_next = smbc_pkg::PH_IDLE;
              end
            endcase
            // reload unless the step ended the transfer
            if (phase_next != smbc_pkg::PH_IDLE) begin
              prescale_count_next = smbc_pkg::reload_value(control_reg[1:0],
                                                           status_bits[smbc_pkg::S_X2]);
            end
          end else begin
            prescale_count_next = prescale_count - 6'd1;
          end
        end
      end
      smbc_pkg::FN_READ: begin
        case (reg_sel)
          smbc_pkg::REG_CTRL: rd = control_reg;
          smbc_pkg::REG_STAT: begin
            pending_clear_next = status_bits[1:0];
            rd = {status_bits[smbc_pkg::S_DONE], status_bits[smbc_pkg::S_COL], 5'd0,
                  status_bits[smbc_pkg::S_X2]};
          end
          smbc_pkg::REG_DATA: begin
            status_bits_next[1:0] = status_bits[1:0] & ~pending_clear;
            pending_clear_next = 2'd0;
            rd = data_reg;
          end
          default: rd = 8'd0;
        endcase
      end
      smbc_pkg::FN_WRITE: begin
        case (reg_sel)
          smbc_pkg::REG_CTRL: begin
            control_reg_next = write_data;
            // drop any transfer when the pins stop being driven
            if ((diff[smbc_pkg::C_MST] || diff[smbc_pkg::C_EN]) &&
                !(write_data[smbc_pkg::C_MST] && write_data[smbc_pkg::C_EN])) begin
              phase_next = smbc_pkg::PH_IDLE;
              prescale_count_next = 6'd0;
              pin_levels_next = smbc_pkg::PINS_RESET;
            end
          end
          smbc_pkg::REG_STAT: begin
            status_bits_next[smbc_pkg::S_X2] = write_data[0];
          end
          smbc_pkg::REG_DATA: begin
            data_reg_next = write_data;
            if (control_reg[smbc_pkg::C_MST] && control_reg[smbc_pkg::C_EN]) begin
              if (phase != smbc_pkg::PH_IDLE) begin
                status_bits_next[smbc_pkg::S_COL] = 1'b1;
                pending_clear_next[smbc_pkg::S_COL] = 1'b0;
              end
              // start a fresh transfer from the written byte
              bits_out_next = 4'd0;
              bits_in_next = 4'd0;
              shift_reg_next = write_data;
              if (!pha) begin
                pin_levels_next[smbc_pkg::P_MOSI] =
                  control_reg[smbc_pkg::C_LSB] ? write_data[0] : write_data[7];
                bits_out_next = 4'd1;
              end
              phase_next = smbc_pkg::PH_START;
              pin_levels_next[smbc_pkg::P_SEL] = 1'b0;
              prescale_count_next = smbc_pkg::reload_value(control_reg[1:0],
                                                           status_bits[smbc_pkg::S_X2]);
            end
            status_bits_next[1:0] = status_bits_next[1:0] & ~pending_clear_next;
            pending_clear_next = 2'd0;
          end
          default: ;
        endcase
      end
      default: begin
        status_bits_next[smbc_pkg::S_DONE] = 1'b0;
      end
    endcase

    // Build the result word from the updated state
    drv_next = control_reg_next[smbc_pkg::C_EN] && control_reg_next[smbc_pkg::C_MST];
    result_next.read_data = rd;
    result_next.irq = status_bits_next[smbc_pkg::S_DONE] && control_reg_next[smbc_pkg::C_IE];
    result_next.lines_driven = drv_next;
    result_next.busy_res = phase_next != smbc_pkg::PH_IDLE;
    if (!drv_next) begin
      result_next.sck_level = 1'b0;
      result_next.mosi_level = 1'b1;
      result_next.select_n = 1'b1;
    end else begin
      result_next.sck_level = (phase_next != smbc_pkg::PH_IDLE) ?
                              pin_levels_next[smbc_pkg::P_SCK] :
                              control_reg_next[smbc_pkg::C_POL];
      result_next.mosi_level = pin_levels_next[smbc_pkg::P_MOSI];
      result_next.select_n = pin_levels_next[smbc_pkg::P_SEL];
    end
  end

  // Hold register state, advance on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg <= 8'd0;
      status_bits <= 3'd0;
      pending_clear <= 2'd0;
      data_reg <= 8'd0;
      shift_reg <= 8'd0;
      phase <= smbc_pkg::PH_IDLE;
      bits_out <= 4'd0;
      bits_in <= 4'd0;
      prescale_count <= 6'd0;
      pin_levels <= smbc_pkg::PINS_RESET;
    end else if (accept) begin
      control_reg <= control_reg_next;
      status_bits <= status_bits_next;
      pending_clear <= pending_clear_next;
      data_reg <= data_reg_next;
      shift_reg <= shift_reg_next;
      phase <= phase_next;
      bits_out <= bits_out_next;
      bits_in <= bits_in_next;
      prescale_count <= prescale_count_next;
      pin_levels <= pin_levels_next;
    end
  end

  // Result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !rsp_stall) begin
        out_valid <= skid_valid || accept;
        skid_valid <= 1'b0;
      end else if (!out_valid) begin
        out_valid <= accept;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !rsp_stall) begin
      out_word <= skid_valid ? skid_word : result_next;
    end else if (!out_valid) begin
      out_word <= result_next;
    end
    if (accept && out_valid && rsp_stall) begin
      skid_word <= result_next;
    end
  end

  assign rsp_valid = out_valid;
  assign read_data = out_word.read_data;
  assign irq = out_word.irq;
  assign sck_level = out_word.sck_level;
  assign mosi_level = out_word.mosi_level;
  assign select_n = out_word.select_n;
  assign lines_driven = out_word.lines_driven;
  assign busy_res = out_word.busy_res;

  // A transfer only runs while the pins are driven
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!busy_res || lines_driven))
    else $error("transfer reported busy with pins undriven");

  // Undriven pins show their idle levels
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !lines_driven) |-> (!sck_level && mosi_level && select_n))
    else $error("undriven pins not at idle levels");

  // Select stays low for the whole transfer
  assert property (@(posedge clk) disable iff (rst)
    (phase != smbc_pkg::PH_IDLE) |-> !pin_levels[smbc_pkg::P_SEL])
    else $error("select high during a transfer");

  // The prescaler rests at zero between transfers
  assert property (@(posedge clk) disable iff (rst)
    (phase == smbc_pkg::PH_IDLE) |-> (prescale_count == 6'd0))
    else $error("prescaler running while idle");

  // The skid stage only fills behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word without result word");

endmodule
